@@ rtl/rcb_pkg.sv @@
package rcb_pkg;

   localparam logic [1:0] CSR_BUMP_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_PAUSE_LENGTH = 2'd1;
   localparam logic [1:0] CSR_BUMP_COUNT   = 2'd2;

   localparam logic OP_QUERY = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam int N_W = 7;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef struct packed {
      logic               valid;
      logic               op;
      logic [5:0]         idx;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vz;
      logic               finished;
      logic               act;
      logic [N_W-1:0]     n;
   } meta_type;

   function automatic logic [15:0] sin_sq_q15(input logic [63:0] a);
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        s;
      logic [63:0]        w;
      int unsigned        i;
      term = a;
      sum  = $signed(a);
      for (i = 1; i <= 8; i++) begin
         term = (term * a) >> 30;
         term = (term * a) >> 30;
         term = term / 64'((2 * i) * (2 * i + 1));
         if (i[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      s = $unsigned(sum);
      w = (s * s) >> 30;
      w = (w + 64'd16384) >> 15;
      if (w > 64'd32768) begin
         w = 64'd32768;
      end
      return w[15:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [32:0] p);
      logic signed [32:0] r;
      r = p >>> 15;
      if (r > 33'sd32767) begin
         return 16'sh7fff;
      end else if (r < -33'sd32768) begin
         return 16'sh8000;
      end
      return r[15:0];
   endfunction

endpackage

@@ rtl/rcb_if.sv @@
interface rcb_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [23:0] position;
   logic [22:0]        span_size;
   logic               centered;
   logic [5:0]         entry_index;
   logic signed [15:0] bump_x;
   logic signed [15:0] bump_y;
   logic signed [15:0] bump_z;

   modport source (output valid, operation, position, span_size, centered, entry_index,
                   bump_x, bump_y, bump_z, input ready);
   modport sink (input valid, operation, position, span_size, centered, entry_index,
                 bump_x, bump_y, bump_z, output ready);
endinterface

interface rcb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] deviation_x;
   logic signed [15:0] deviation_y;
   logic signed [15:0] deviation_z;
   logic               finished;

   modport source (output valid, deviation_x, deviation_y, deviation_z, finished,
                   input ready);
   modport sink (input valid, deviation_x, deviation_y, deviation_z, finished,
                 output ready);
endinterface

@@ rtl/rcb_udiv.sv @@
module rcb_udiv #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 25,
   parameter int Q_W   = 7
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quot,
   output logic [NUM_W-1:0] rem
);

   localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [NUM_W-1:0] rem_ff [Q_W];
   logic [Q_W-1:0]   q_ff [Q_W];

   for (genvar s = 0; s < Q_W; s++) begin : g_step
      logic [NUM_W-1:0] rem_prev;
      logic [Q_W-1:0]   q_prev;
      logic [CW-1:0]    trial;
      logic             take;

      if (s == 0) begin : g_first
         assign rem_prev = num;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign q_prev   = q_ff[s-1];
      end

      assign trial = CW'(den) << (Q_W - 1 - s);
      assign take  = CW'(rem_prev) >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= take ? NUM_W'(CW'(rem_prev) - trial) : rem_prev;
            q_ff[s]   <= Q_W'({q_prev, take});
         end
      end
   end

   assign quot = q_ff[Q_W-1];
   assign rem  = rem_ff[Q_W-1];

endmodule

@@ rtl/rcb_wrom.sv @@
module rcb_wrom #(
   parameter int PHASE_STEPS = 1024,
   parameter int KW          = 11
) (
   input  logic          clock,
   input  logic          en,
   input  logic          act,
   input  logic [KW-1:0] k,
   output logic [15:0]   weight
);

   logic [15:0] wtab [PHASE_STEPS+1];
   logic [15:0] w_ff;

   for (genvar g = 0; g <= PHASE_STEPS; g++) begin : g_tab
      localparam logic [63:0] M = (g <= PHASE_STEPS - g) ? 64'(g) : 64'(PHASE_STEPS - g);
      localparam logic [63:0] A = (M * rcb_pkg::PI_Q30) / PHASE_STEPS;
      assign wtab[g] = rcb_pkg::sin_sq_q15(A);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= act ? wtab[k] : '0;
      end
   end

   assign weight = w_ff;

endmodule

@@ rtl/rcb_btab.sv @@
module rcb_btab #(
   parameter int MAX_BUMPS = 64
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic                      wr,
   input  logic [5:0]                waddr,
   input  logic [47:0]               wdata,
   input  logic [rcb_pkg::N_W-1:0]   raddr,
   output logic [47:0]               rdata
);

   localparam int AW = (MAX_BUMPS > 1) ? $clog2(MAX_BUMPS) : 1;

   logic [47:0] mem [MAX_BUMPS];
   logic [47:0] rd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (wr && (32'(waddr) < MAX_BUMPS)) begin
            mem[AW'(waddr)] <= wdata;
         end
         rd_ff <= mem[AW'(raddr)];
      end
   end

   assign rdata = rd_ff;

endmodule

@@ rtl/raised_cosine_bump_profile.sv @@
// Throughput: one item per cycle unless the output stalls; the bump-index divider (7 stages)
// and the phase divider (clog2(PHASE_STEPS + 1) stages) are fully pipelined and the table
// is read once per item.
// Whole pipeline advances together when the output register is empty or being taken.
// Reset: synchronous; clears valid bits, sets bump_length and pause_length to 256 and
// bump_count to 0. Bump table contents are undefined until written.
module raised_cosine_bump_profile #(
   parameter int MAX_BUMPS   = 64,
   parameter int PHASE_STEPS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   rcb_req_if.sink           req_chan,
   rcb_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [22:0]       csr_wdata
);

   localparam int KW     = $clog2(PHASE_STEPS + 1);
   localparam int NUM2_W = 24 + KW;
   localparam int D1     = 7;

   logic [22:0] bl_ff, pl_ff;
   logic [6:0]  bc_ff;
   logic [6:0]  cnt_in;
   logic [23:0] per_in;
   logic [24:0] per2_ff;
   logic [30:0] seq_ff;
   logic [23:0] b2_ff;
   logic        bl_nz_ff;

   logic adv;

   rcb_pkg::meta_type a_in, a_ff;
   logic signed [23:0] pos_a_ff;
   logic [22:0]        span_a_ff;
   logic               cen_a_ff;

   rcb_pkg::meta_type  b_in, b_ff;
   logic signed [33:0] p2;
   logic [31:0]        p2b_in, p2b_ff;

   rcb_pkg::meta_type  m1_ff [D1];
   logic [D1-1:0]      q1;
   logic [31:0]        r1;

   rcb_pkg::meta_type  c_in, c_ff;
   logic [NUM2_W-1:0]  num2_in, num2_ff;

   rcb_pkg::meta_type  m2_ff [KW];
   logic [KW-1:0]      q2;
   logic [NUM2_W-1:0]  r2;
   logic [KW-1:0]      k;

   rcb_pkg::meta_type  e_ff, f_ff;
   logic [15:0]        weight;
   logic [47:0]        rdata;
   logic signed [32:0] px_ff, py_ff, pz_ff;
   logic signed [32:0] we;

   logic               rsp_valid_ff;
   logic signed [15:0] dx_ff, dy_ff, dz_ff;
   logic               fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bl_ff <= 23'd256;
         pl_ff <= 23'd256;
         bc_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            rcb_pkg::CSR_BUMP_LENGTH:  bl_ff <= csr_wdata;
            rcb_pkg::CSR_PAUSE_LENGTH: pl_ff <= csr_wdata;
            rcb_pkg::CSR_BUMP_COUNT:   bc_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign cnt_in = (32'(bc_ff) > MAX_BUMPS) ? 7'(MAX_BUMPS) : bc_ff;
   assign per_in = 24'(bl_ff) + 24'(pl_ff);

   always_ff @(posedge clock) begin
      per2_ff  <= {per_in, 1'b0};
      seq_ff   <= 31'(cnt_in) * 31'(per_in);
      b2_ff    <= {bl_ff, 1'b0};
      bl_nz_ff <= (bl_ff != '0);
   end

   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_comb begin
      a_in          = '0;
      a_in.valid    = req_chan.valid;
      a_in.op       = req_chan.operation;
      a_in.idx      = req_chan.entry_index;
      a_in.vx       = req_chan.bump_x;
      a_in.vy       = req_chan.bump_y;
      a_in.vz       = req_chan.bump_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
      end else if (adv) begin
         a_ff <= a_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_a_ff  <= req_chan.position;
         span_a_ff <= req_chan.span_size;
         cen_a_ff  <= req_chan.centered;
      end
   end

   always_comb begin
      p2 = $signed({{9{pos_a_ff[23]}}, pos_a_ff, 1'b0});
      if (cen_a_ff) begin
         p2 = p2 - $signed({11'b0, span_a_ff}) + $signed({3'b0, seq_ff});
      end
      b_in          = a_ff;
      b_in.finished = (a_ff.op == rcb_pkg::OP_QUERY) &&
                      ((p2 < 0) || (p2 > $signed({2'b0, seq_ff, 1'b0})));
      b_in.act      = (a_ff.op == rcb_pkg::OP_QUERY) && !p2[33] && bl_nz_ff &&
                      (p2 < $signed({2'b0, seq_ff, 1'b0}));
      p2b_in        = b_in.act ? p2[31:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0;
      end else if (adv) begin
         b_ff <= b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2b_ff <= p2b_in;
      end
   end

   rcb_udiv #(.NUM_W(32), .DEN_W(25), .Q_W(D1)) u_div_bump (
      .clock (clock),
      .en    (adv),
      .num   (p2b_ff),
      .den   (per2_ff),
      .quot  (q1),
      .rem   (r1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < D1; i++) begin
            m1_ff[i] <= '0;
         end
      end else if (adv) begin
         m1_ff[0] <= b_ff;
         for (int i = 1; i < D1; i++) begin
            m1_ff[i] <= m1_ff[i-1];
         end
      end
   end

   always_comb begin
      c_in     = m1_ff[D1-1];
      c_in.act = m1_ff[D1-1].act && (r1 <= 32'(b2_ff));
      c_in.n   = rcb_pkg::N_W'(q1);
      num2_in  = c_in.act ?
                 NUM2_W'(r1[23:0]) * NUM2_W'(PHASE_STEPS) + NUM2_W'(bl_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff <= '0;
      end else if (adv) begin
         c_ff <= c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num2_ff <= num2_in;
      end
   end

   rcb_udiv #(.NUM_W(NUM2_W), .DEN_W(24), .Q_W(KW)) u_div_phase (
      .clock (clock),
      .en    (adv),
      .num   (num2_ff),
      .den   (b2_ff),
      .quot  (q2),
      .rem   (r2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KW; i++) begin
            m2_ff[i] <= '0;
         end
      end else if (adv) begin
         m2_ff[0] <= c_ff;
         for (int i = 1; i < KW; i++) begin
            m2_ff[i] <= m2_ff[i-1];
         end
      end
   end

   assign k = (32'(q2) > PHASE_STEPS) ? KW'(PHASE_STEPS) : q2;

   rcb_wrom #(.PHASE_STEPS(PHASE_STEPS), .KW(KW)) u_wrom (
      .clock  (clock),
      .en     (adv),
      .act    (m2_ff[KW-1].act && (r2 == r2)),
      .k      (k),
      .weight (weight)
   );

   rcb_btab #(.MAX_BUMPS(MAX_BUMPS)) u_btab (
      .clock (clock),
      .en    (adv),
      .wr    (m2_ff[KW-1].valid && (m2_ff[KW-1].op == rcb_pkg::OP_WRITE)),
      .waddr (m2_ff[KW-1].idx),
      .wdata ({m2_ff[KW-1].vx, m2_ff[KW-1].vy, m2_ff[KW-1].vz}),
      .raddr (m2_ff[KW-1].n),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff <= '0;
         f_ff <= '0;
      end else if (adv) begin
         e_ff <= m2_ff[KW-1];
         f_ff <= e_ff;
      end
   end

   assign we = 33'($signed({1'b0, weight}));

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= 33'($signed(rdata[47:32])) * we + 33'sd16384;
         py_ff <= 33'($signed(rdata[31:16])) * we + 33'sd16384;
         pz_ff <= 33'($signed(rdata[15:0])) * we + 33'sd16384;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= f_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff  <= f_ff.act ? rcb_pkg::sat16(px_ff) : '0;
         dy_ff  <= f_ff.act ? rcb_pkg::sat16(py_ff) : '0;
         dz_ff  <= f_ff.act ? rcb_pkg::sat16(pz_ff) : '0;
         fin_ff <= f_ff.finished;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.deviation_x = dx_ff;
   assign rsp_chan.deviation_y = dy_ff;
   assign rsp_chan.deviation_z = dz_ff;
   assign rsp_chan.finished    = fin_ff;

endmodule

@@ rtl/rcb_checker.sv @@
module rcb_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] deviation_x,
   input logic signed [15:0] deviation_y,
   input logic signed [15:0] deviation_z,
   input logic               finished
);

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output register state");

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_bump_not_finished: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (deviation_x != 0 || deviation_y != 0 || deviation_z != 0))
      |-> !finished)
      else $error("nonzero deviation with finished set");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(deviation_x) &&
      $stable(deviation_y) && $stable(deviation_z) && $stable(finished)))
      else $error("stalled result changed");

endmodule

bind raised_cosine_bump_profile rcb_checker u_rcb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .deviation_x (rsp_chan.deviation_x),
   .deviation_y (rsp_chan.deviation_y),
   .deviation_z (rsp_chan.deviation_z),
   .finished    (rsp_chan.finished)
);
